@@ rtl/min_heap_priority_queue_top_defines.svh @@
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top_defines
// assertion macros used by the heap queue top
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication on i_clk, off while in reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication on i_clk, off while in reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared constants, codes and control types of the min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // default heap capacity
    localparam int CAPACITY_DEF = 128;

    // fixed field widths
    localparam int KEY_W   = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int CNT_O_W = 8;
    localparam int STAT_W  = 3;
    localparam int CMD_W   = 4;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_DECREASE = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_LARGER = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADIDX = 3'd4;

    // datapath commands
    localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ACCEPT    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SET_STAT  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_INS_START = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DEC_START = 4'd4;
    localparam logic [CMD_W-1:0] CMD_EXT_START = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UP_READ   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_UP_CMP    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DN_LOAD   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_DN_READL  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_DN_READR  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_DN_CMP    = 4'd11;
    localparam logic [CMD_W-1:0] CMD_LOAD_OUT  = 4'd12;

    // command from controller to datapath
    typedef struct packed {
        logic [CMD_W-1:0]  code;
        logic [STAT_W-1:0] stat;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            idx_bad;
        logic            one_left;
        logic            pos_zero;
        logic            key_larger;
        logic            up_swap;
        logic            lc_out;
        logic            dn_swap;
    } t_flags;

endpackage

@@ rtl/mhpq_ram.sv @@
// ----------------------------------------------------------------------------
// mhpq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mhpq_dp.sv @@
// ----------------------------------------------------------------------------
// mhpq_dp
// heap datapath: key store, fill count, sift position, compares, result word
// ----------------------------------------------------------------------------
module mhpq_dp #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [mhpq_pkg::OP_W-1:0]           i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0]   i_key,
    input  logic [mhpq_pkg::IDX_W-1:0]          i_index,
    input  mhpq_pkg::t_cmd                      i_cmd,
    output mhpq_pkg::t_flags                    o_flags,
    output logic signed [mhpq_pkg::KEY_W-1:0]   o_extracted,
    output logic signed [mhpq_pkg::KEY_W-1:0]   o_top,
    output logic [mhpq_pkg::CNT_O_W-1:0]        o_count,
    output logic [mhpq_pkg::STAT_W-1:0]         o_status
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NW   = CW + 1;
    localparam int CMPW = (CW > mhpq_pkg::IDX_W) ? CW : mhpq_pkg::IDX_W;

    // held item and heap control
    logic [mhpq_pkg::OP_W-1:0]         r_op;
    logic signed [mhpq_pkg::KEY_W-1:0] r_key;
    logic [mhpq_pkg::IDX_W-1:0]        r_idx;
    logic [CW-1:0]                     r_count;
    logic [AW-1:0]                     r_pos;
    logic signed [mhpq_pkg::KEY_W-1:0] r_root;
    logic signed [mhpq_pkg::KEY_W-1:0] r_lval;
    logic                              r_rvalid;
    logic signed [mhpq_pkg::KEY_W-1:0] r_removed;
    logic [mhpq_pkg::STAT_W-1:0]       r_status;

    // result word
    logic signed [mhpq_pkg::KEY_W-1:0] r_o_extracted;
    logic signed [mhpq_pkg::KEY_W-1:0] r_o_top;
    logic [mhpq_pkg::CNT_O_W-1:0]      r_o_count;
    logic [mhpq_pkg::STAT_W-1:0]       r_o_status;

    // ram port signals
    logic                              we;
    logic [AW-1:0]                     wr_addr;
    logic signed [mhpq_pkg::KEY_W-1:0] wr_data;
    logic                              rd_en;
    logic [AW-1:0]                     rd_addr;
    logic signed [mhpq_pkg::KEY_W-1:0] rd_data;

    // tree arithmetic
    logic [NW-1:0]                     cnt_ext;
    logic [NW-1:0]                     lc;
    logic [NW-1:0]                     rc;
    logic [AW-1:0]                     pos_m1;
    logic [AW-1:0]                     parent;
    logic                              rc_in;
    logic                              l_less;
    logic                              r_less_c;
    logic signed [mhpq_pkg::KEY_W-1:0] l_best;
    logic signed [mhpq_pkg::KEY_W-1:0] dn_val;
    logic [AW-1:0]                     dn_pos;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::KEY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // child and parent positions
    assign cnt_ext = NW'(r_count);
    assign lc      = NW'({r_pos, 1'b1});
    assign rc      = lc + NW'(1);
    assign pos_m1  = r_pos - AW'(1);
    assign parent  = pos_m1 >> 1;
    assign rc_in   = rc < cnt_ext;

    // smallest of node, left child and right child (right in read data)
    assign l_less   = r_lval < r_key;
    assign l_best   = l_less ? r_lval : r_key;
    assign r_less_c = r_rvalid && (rd_data < l_best);
    assign dn_val   = r_less_c ? rd_data : r_lval;
    assign dn_pos   = r_less_c ? AW'(rc) : AW'(lc);

    // status toward the controller
    always_comb begin
        o_flags.op         = r_op;
        o_flags.full       = r_count == CW'(CAPACITY);
        o_flags.empty      = r_count == '0;
        o_flags.idx_bad    = CMPW'(r_idx) >= CMPW'(r_count);
        o_flags.one_left   = r_count == CW'(1);
        o_flags.pos_zero   = r_pos == '0;
        o_flags.key_larger = r_key > rd_data;
        o_flags.up_swap    = r_key < rd_data;
        o_flags.lc_out     = lc >= cnt_ext;
        o_flags.dn_swap    = l_less || r_less_c;
    end

    // store access per command
    always_comb begin
        we      = 1'b0;
        wr_addr = r_pos;
        wr_data = r_key;
        rd_en   = 1'b0;
        rd_addr = r_pos;
        case (i_cmd.code)
            mhpq_pkg::CMD_DEC_START: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx);
            end
            mhpq_pkg::CMD_EXT_START: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_count - CW'(1));
            end
            mhpq_pkg::CMD_UP_READ: begin
                if (o_flags.pos_zero) begin
                    we = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            mhpq_pkg::CMD_UP_CMP: begin
                we = 1'b1;
                if (o_flags.up_swap) begin
                    wr_data = rd_data;
                end
            end
            mhpq_pkg::CMD_DN_READL: begin
                if (o_flags.lc_out) begin
                    we = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lc);
                end
            end
            mhpq_pkg::CMD_DN_READR: begin
                rd_en   = rc_in;
                rd_addr = AW'(rc);
            end
            mhpq_pkg::CMD_DN_CMP: begin
                we = 1'b1;
                if (o_flags.dn_swap) begin
                    wr_data = dn_val;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.code)
                mhpq_pkg::CMD_INS_START: r_count <= r_count + CW'(1);
                mhpq_pkg::CMD_EXT_START: r_count <= r_count - CW'(1);
                default:                 r_count <= r_count;
            endcase
        end
    end

    // item, sift and result registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.code)
            mhpq_pkg::CMD_ACCEPT: begin
                r_op      <= i_operation;
                r_key     <= i_key;
                r_idx     <= i_index;
                r_removed <= '0;
                r_status  <= mhpq_pkg::ST_OK;
            end
            mhpq_pkg::CMD_SET_STAT: begin
                r_status <= i_cmd.stat;
            end
            mhpq_pkg::CMD_INS_START: begin
                r_pos <= AW'(r_count);
            end
            mhpq_pkg::CMD_DEC_START: begin
                r_pos <= AW'(r_idx);
            end
            mhpq_pkg::CMD_EXT_START: begin
                r_removed <= r_root;
            end
            mhpq_pkg::CMD_UP_CMP: begin
                if (o_flags.up_swap) begin
                    r_pos <= parent;
                end
            end
            mhpq_pkg::CMD_DN_LOAD: begin
                r_key <= rd_data;
                r_pos <= '0;
            end
            mhpq_pkg::CMD_DN_READR: begin
                r_lval   <= rd_data;
                r_rvalid <= rc_in;
            end
            mhpq_pkg::CMD_DN_CMP: begin
                if (o_flags.dn_swap) begin
                    r_pos <= dn_pos;
                end
            end
            mhpq_pkg::CMD_LOAD_OUT: begin
                r_o_extracted <= r_removed;
                r_o_top       <= o_flags.empty ? '0 : r_root;
                r_o_count     <= mhpq_pkg::CNT_O_W'(r_count);
                r_o_status    <= r_status;
            end
            default: begin
                r_pos <= r_pos;
            end
        endcase
    end

    // copy of the root entry, kept for extract and top
    always_ff @(posedge i_clk) begin
        if (we && (wr_addr == '0)) begin
            r_root <= wr_data;
        end
    end

    assign o_extracted = r_o_extracted;
    assign o_top       = r_o_top;
    assign o_count     = r_o_count;
    assign o_status    = r_o_status;

endmodule

@@ rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// heap controller: handshakes, operation dispatch and sift sequencing
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  mhpq_pkg::t_flags i_flags,
    output mhpq_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_DEC_CHK  = 4'd2;
    localparam logic [3:0] S_UP_RD    = 4'd3;
    localparam logic [3:0] S_UP_CMP   = 4'd4;
    localparam logic [3:0] S_DN_LOAD  = 4'd5;
    localparam logic [3:0] S_DN_RDL   = 4'd6;
    localparam logic [3:0] S_DN_RDR   = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // next state and command
    always_comb begin
        n_state    = r_state;
        o_cmd.code = mhpq_pkg::CMD_NONE;
        o_cmd.stat = mhpq_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.code = mhpq_pkg::CMD_ACCEPT;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_DONE;
                case (i_flags.op)
                    mhpq_pkg::OP_INSERT: begin
                        if (i_flags.full) begin
                            o_cmd.code = mhpq_pkg::CMD_SET_STAT;
                            o_cmd.stat = mhpq_pkg::ST_FULL;
                        end else begin
                            o_cmd.code = mhpq_pkg::CMD_INS_START;
                            n_state    = S_UP_RD;
                        end
                    end
                    mhpq_pkg::OP_DECREASE: begin
                        if (i_flags.idx_bad) begin
                            o_cmd.code = mhpq_pkg::CMD_SET_STAT;
                            o_cmd.stat = mhpq_pkg::ST_BADIDX;
                        end else begin
                            o_cmd.code = mhpq_pkg::CMD_DEC_START;
                            n_state    = S_DEC_CHK;
                        end
                    end
                    mhpq_pkg::OP_EXTRACT: begin
                        if (i_flags.empty) begin
                            o_cmd.code = mhpq_pkg::CMD_SET_STAT;
                            o_cmd.stat = mhpq_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.code = mhpq_pkg::CMD_EXT_START;
                            n_state    = i_flags.one_left ? S_DONE : S_DN_LOAD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DEC_CHK: begin
                if (i_flags.key_larger) begin
                    o_cmd.code = mhpq_pkg::CMD_SET_STAT;
                    o_cmd.stat = mhpq_pkg::ST_LARGER;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_UP_RD;
                end
            end
            // one sift-up level: read parent, then compare and move
            S_UP_RD: begin
                o_cmd.code = mhpq_pkg::CMD_UP_READ;
                n_state    = i_flags.pos_zero ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.code = mhpq_pkg::CMD_UP_CMP;
                n_state    = i_flags.up_swap ? S_UP_RD : S_DONE;
            end
            // one sift-down level: read left, read right, compare and move
            S_DN_LOAD: begin
                o_cmd.code = mhpq_pkg::CMD_DN_LOAD;
                n_state    = S_DN_RDL;
            end
            S_DN_RDL: begin
                o_cmd.code = mhpq_pkg::CMD_DN_READL;
                n_state    = i_flags.lc_out ? S_DONE : S_DN_RDR;
            end
            S_DN_RDR: begin
                o_cmd.code = mhpq_pkg::CMD_DN_READR;
                n_state    = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.code = mhpq_pkg::CMD_DN_CMP;
                n_state    = i_flags.dn_swap ? S_DN_RDL : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.code = mhpq_pkg::CMD_LOAD_OUT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid: set on load, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.code == mhpq_pkg::CMD_LOAD_OUT) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/min_heap_priority_queue_top.sv @@
// Flow: one word at a time, the next taken the cycle after the result loads; the sift
// loop over the key store (a read and a compare state per level up, two reads and a
// compare down) sets the pace.
// Reset: synchronous, clears the fill count and both handshakes; the key store is not cleared.
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// binary min-heap priority queue: insert, decrease key, extract minimum
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_top_defines.svh"

module min_heap_priority_queue_top #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mhpq_pkg::OP_W-1:0]         i_operation,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_key,
    input  logic [mhpq_pkg::IDX_W-1:0]        i_index,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_extracted,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_top,
    output logic [mhpq_pkg::CNT_O_W-1:0]      o_count,
    output logic [mhpq_pkg::STAT_W-1:0]       o_status
);

    mhpq_pkg::t_cmd   cmd;
    mhpq_pkg::t_flags flags;

    // sequencer
    mhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    // store and arithmetic
    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_index     (i_index),
        .i_cmd       (cmd),
        .o_flags     (flags),
        .o_extracted (o_extracted),
        .o_top       (o_top),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    // an accepted word keeps the input side stalled while it is worked on
    `MHPQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // an empty report leaves nothing held and nothing removed
    `MHPQ_ASSERT_NOW(a_empty_report, o_out_valid && (o_status == mhpq_pkg::ST_EMPTY), (o_count == '0) && (o_extracted == '0))
    // a full report carries the capacity as count
    `MHPQ_ASSERT_NOW(a_full_report, o_out_valid && (o_status == mhpq_pkg::ST_FULL), o_count == mhpq_pkg::CNT_O_W'(CAPACITY))
    // a new word is loaded only once the previous one has left
    `MHPQ_ASSERT_NEXT(a_no_overwrite, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_top))

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the min-heap priority queue: directed corner words,
// then random insert/decrease/extract traffic in fill, drain and mixed phases,
// with each result checked against a behavioral heap kept in a scoreboard
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HEAP_CAP     = mhpq_pkg::CAPACITY_DEF;
    localparam int          RANDOM_WORDS = 930;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SETTLE_CYC   = 40;
    localparam logic [mhpq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // expected contents of one result word
    typedef struct {
        logic [mhpq_pkg::KEY_W-1:0]   extracted;
        logic [mhpq_pkg::KEY_W-1:0]   top;
        logic [mhpq_pkg::CNT_O_W-1:0] count;
        logic [mhpq_pkg::STAT_W-1:0]  status;
    } t_heap_result;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_traffic_mix;

    // behavioral heap plus queue of pending result words
    class t_heap_scoreboard;
        int           keys [HEAP_CAP];
        int unsigned  fill;
        int unsigned  peak_fill;
        t_heap_result pending_q [$];
        int unsigned  errors;
        int unsigned  words_in;
        int unsigned  results_ok;
        int unsigned  status_seen [8];

        function new();
            fill = 0;
            peak_fill = 0;
            errors = 0;
            words_in = 0;
            results_ok = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void swap_keys(int unsigned a, int unsigned b);
            int t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void sift_up(int unsigned pos);
            int unsigned parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (keys[pos] >= keys[parent]) break;
                swap_keys(pos, parent);
                pos = parent;
            end
        endfunction

        // stops as soon as no child is strictly smaller
        function void sift_down(int unsigned pos);
            int unsigned lc;
            int unsigned best;
            forever begin
                lc = 2 * pos + 1;
                best = pos;
                if (lc < fill && keys[lc] < keys[best]) best = lc;
                if (lc + 1 < fill && keys[lc + 1] < keys[best]) best = lc + 1;
                if (best == pos) break;
                swap_keys(pos, best);
                pos = best;
            end
        endfunction

        // apply one accepted request word and queue its result
        function void note_request(logic [mhpq_pkg::OP_W-1:0] op,
                                   logic [mhpq_pkg::KEY_W-1:0] key,
                                   logic [mhpq_pkg::IDX_W-1:0] idx);
            t_heap_result r;
            r.extracted = '0;
            r.status = mhpq_pkg::ST_OK;
            words_in++;
            case (op)
                mhpq_pkg::OP_INSERT: begin
                    if (fill >= HEAP_CAP) begin
                        r.status = mhpq_pkg::ST_FULL;
                    end else begin
                        keys[fill] = key;
                        fill++;
                        sift_up(fill - 1);
                    end
                end
                mhpq_pkg::OP_DECREASE: begin
                    if (idx >= fill) begin
                        r.status = mhpq_pkg::ST_BADIDX;
                    end else if (int'(key) > keys[idx]) begin
                        r.status = mhpq_pkg::ST_LARGER;
                    end else begin
                        keys[idx] = key;
                        sift_up(idx);
                    end
                end
                mhpq_pkg::OP_EXTRACT: begin
                    if (fill == 0) begin
                        r.status = mhpq_pkg::ST_EMPTY;
                    end else begin
                        r.extracted = keys[0];
                        fill--;
                        if (fill > 0) begin
                            keys[0] = keys[fill];
                            sift_down(0);
                        end
                    end
                end
                default: ;
            endcase
            r.top = (fill > 0) ? keys[0] : 0;
            r.count = fill[mhpq_pkg::CNT_O_W-1:0];
            if (fill > peak_fill) peak_fill = fill;
            status_seen[r.status]++;
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [mhpq_pkg::KEY_W-1:0] got,
                             logic [mhpq_pkg::KEY_W-1:0] want);
            $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic [mhpq_pkg::KEY_W-1:0] ext, logic [mhpq_pkg::KEY_W-1:0] top,
                          logic [mhpq_pkg::CNT_O_W-1:0] cnt,
                          logic [mhpq_pkg::STAT_W-1:0] st);
            t_heap_result w;
            if (pending_q.size() == 0) begin
                report_mismatch("result word with nothing pending, top", top, '0);
            end else begin
                w = pending_q.pop_front();
                results_ok++;
                if (ext !== w.extracted) report_mismatch("extracted", ext, w.extracted);
                if (top !== w.top) report_mismatch("top", top, w.top);
                if (cnt !== w.count)
                    report_mismatch("count", mhpq_pkg::KEY_W'(cnt),
                                    mhpq_pkg::KEY_W'(w.count));
                if (st !== w.status)
                    report_mismatch("status", mhpq_pkg::KEY_W'(st),
                                    mhpq_pkg::KEY_W'(w.status));
            end
        endtask
    endclass

    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_stall;
    logic [mhpq_pkg::OP_W-1:0]           i_operation = mhpq_pkg::OP_INSERT;
    logic signed [mhpq_pkg::KEY_W-1:0]   i_key       = '0;
    logic [mhpq_pkg::IDX_W-1:0]          i_index     = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [mhpq_pkg::KEY_W-1:0]   o_extracted;
    logic signed [mhpq_pkg::KEY_W-1:0]   o_top;
    logic [mhpq_pkg::CNT_O_W-1:0]        o_count;
    logic [mhpq_pkg::STAT_W-1:0]         o_status;

    t_heap_scoreboard sb = new();
    bit               calm = 1'b0;
    int unsigned      cycle_count = 0;

    min_heap_priority_queue_top #(
        .CAPACITY (HEAP_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_index     (i_index),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_extracted (o_extracted),
        .o_top       (o_top),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // random output stall, none during the calm stretch
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_extracted, o_top, o_count, o_status);
    end

    // present one request word and hold it until accepted
    task automatic send_word(input logic [mhpq_pkg::OP_W-1:0] op,
                             input logic [mhpq_pkg::KEY_W-1:0] key,
                             input logic [mhpq_pkg::IDX_W-1:0] idx);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_index     <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(op, key, idx);
        // occasional sender gap
        if (!calm && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // mix of extremes, a tight band with duplicates, and full-range keys
    function automatic logic [mhpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3, 4, 5: return $urandom_range(0, 40) - 20;
            default: return $urandom();
        endcase
    endfunction

    // random heap position over the whole index range
    function automatic logic [mhpq_pkg::IDX_W-1:0] pick_idx();
        return mhpq_pkg::IDX_W'($urandom_range(0, HEAP_CAP - 1));
    endfunction

    // decrease: mostly a valid index with a smaller or equal key
    task automatic send_decrease();
        logic [mhpq_pkg::IDX_W-1:0] idx;
        longint                     nk;
        int unsigned                roll;
        if (sb.fill > 0 && $urandom_range(0, 9) != 0)
            idx = mhpq_pkg::IDX_W'($urandom_range(0, sb.fill - 1));
        else
            idx = pick_idx();
        roll = $urandom_range(0, 99);
        if (idx < sb.fill && roll < 60) begin
            nk = longint'(sb.keys[idx]) - $urandom_range(0, 50);
            if (nk < -64'sd2147483648) nk = -64'sd2147483648;
            send_word(mhpq_pkg::OP_DECREASE, nk[mhpq_pkg::KEY_W-1:0], idx);
        end else if (idx < sb.fill && roll < 75) begin
            send_word(mhpq_pkg::OP_DECREASE, sb.keys[idx], idx);
        end else begin
            send_word(mhpq_pkg::OP_DECREASE, pick_key(), idx);
        end
    endtask

    initial begin
        t_traffic_mix mix;
        int unsigned  phase_left;
        int unsigned  phase_no;
        int unsigned  ins_pct;
        int unsigned  dec_pct;
        int unsigned  roll;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: empty heap, single key, extremes, decrease cases
        send_word(mhpq_pkg::OP_EXTRACT, '0, '0);
        send_word(mhpq_pkg::OP_DECREASE, 32'h8000_0000, 7'd0);
        send_word(OP_UNUSED, 32'hffff_ffff, 7'h7f);
        send_word(mhpq_pkg::OP_INSERT, 32'h7fff_ffff, '0);
        send_word(mhpq_pkg::OP_EXTRACT, '0, '0);
        send_word(mhpq_pkg::OP_INSERT, 32'h7fff_ffff, '0);
        send_word(mhpq_pkg::OP_INSERT, 32'h8000_0000, '0);
        send_word(mhpq_pkg::OP_INSERT, 32'h0000_0000, '0);
        send_word(mhpq_pkg::OP_INSERT, 32'hffff_ffff, '0);
        send_word(mhpq_pkg::OP_INSERT, 32'd5, '0);
        send_word(mhpq_pkg::OP_DECREASE, 32'h7fff_ffff, 7'd0);
        send_word(mhpq_pkg::OP_DECREASE, sb.keys[1], 7'd1);
        send_word(mhpq_pkg::OP_DECREASE, 32'h8000_0000, 7'd4);
        send_word(mhpq_pkg::OP_DECREASE, 32'h8000_0000, 7'd5);
        send_word(mhpq_pkg::OP_DECREASE, 32'h8000_0000, 7'h7f);
        send_word(OP_UNUSED, '0, '0);
        repeat (6) send_word(mhpq_pkg::OP_EXTRACT, '0, '0);
        i_in_valid <= 1'b0;
        // hold off until the heap has answered everything
        wait_drained();
        @(posedge i_clk);

        // random traffic: first a fill to capacity, then a drain, then mixed
        phase_left = 0;
        phase_no = 0;
        mix = MIX_GROW;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase_left == 0) begin
                if (phase_no == 0) mix = MIX_GROW;
                else if (phase_no == 1) mix = MIX_SHRINK;
                else mix = t_traffic_mix'($urandom_range(0, 2));
                phase_left = (phase_no < 2) ? 180 : $urandom_range(40, 160);
                phase_no++;
            end
            phase_left--;
            calm = (n >= 420 && n < 580);
            if (n == 300) begin
                i_in_valid <= 1'b0;
                wait_drained();
                @(posedge i_clk);
            end
            case (mix)
                MIX_GROW:   begin ins_pct = 80; dec_pct = 10; end
                MIX_SHRINK: begin ins_pct = 15; dec_pct = 15; end
                default:    begin ins_pct = 33; dec_pct = 32; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_word(OP_UNUSED, pick_key(), pick_idx());
            else if (roll < 2 + ins_pct)
                send_word(mhpq_pkg::OP_INSERT, pick_key(), pick_idx());
            else if (roll < 2 + ins_pct + dec_pct)
                send_decrease();
            else
                send_word(mhpq_pkg::OP_EXTRACT, pick_key(), pick_idx());
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // drain, then watch for stray result words
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch("results left pending", sb.pending_q.size(), '0);

        $display("run: %0d request words, %0d results checked, peak fill %0d of %0d",
                 sb.words_in, sb.results_ok, sb.peak_fill, HEAP_CAP);
        $display("statuses: ok %0d, full %0d, empty %0d, key larger %0d, bad index %0d",
                 sb.status_seen[mhpq_pkg::ST_OK], sb.status_seen[mhpq_pkg::ST_FULL],
                 sb.status_seen[mhpq_pkg::ST_EMPTY], sb.status_seen[mhpq_pkg::ST_LARGER],
                 sb.status_seen[mhpq_pkg::ST_BADIDX]);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
